FILE: src/mps_pkg.sv
package mps_pkg;

	localparam int MAX_PSTATES = 8;
	localparam int SUM_WIDTH   = 48;

	localparam int MPKI_W  = 10;
	localparam int NUM_W   = 4;
	localparam int PIDX_W  = 3;
	localparam int CNT32_W = 32;

	localparam int IDX_W    = $clog2(MAX_PSTATES);
	localparam int MX_IDX_W = $clog2(MPKI_W);

	// misses per thousand instructions, doubled for the half-up rounding
	localparam int SCALE  = 1000;
	localparam int M_MAX  = 2 * SCALE * MAX_PSTATES;
	localparam int CW     = $clog2(M_MAX + 1);
	localparam int CNT_W  = $clog2(CW);
	localparam int PW     = SUM_WIDTH + CW;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_MPKI    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PSTATES = 2'd1;

	localparam logic [MPKI_W-1:0] MAX_MPKI_RST    = 10'd100;
	localparam logic [NUM_W-1:0]  NUM_PSTATES_RST = 4'd2;

	typedef struct packed {
		logic               action;
		logic [CNT32_W-1:0] llc_misses;
		logic [CNT32_W-1:0] instructions;
	} item_t;

	typedef struct packed {
		logic [PIDX_W-1:0] pstate_index;
		logic              changed;
	} result_t;

	typedef struct packed {
		logic add;
		logic clr;
	} acc_ctrl_t;

	typedef struct packed {
		logic              start;
		logic [IDX_W-1:0]  n;
		logic [MPKI_W-1:0] mx;
	} unit_req_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] idx;
	} unit_stat_t;

endpackage

FILE: src/mps_accum.sv
module mps_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mps_pkg::acc_ctrl_t            ctrl,
	input  logic [mps_pkg::CNT32_W-1:0]   llc_misses,
	input  logic [mps_pkg::CNT32_W-1:0]   instructions,
	output logic [mps_pkg::SUM_WIDTH-1:0] miss_sum,
	output logic [mps_pkg::SUM_WIDTH-1:0] instr_sum
);
	import mps_pkg::*;

	logic [SUM_WIDTH-1:0] miss_q, instr_q;
	logic [SUM_WIDTH:0]   miss_add, instr_add;

	assign miss_add  = {1'b0, miss_q} + (SUM_WIDTH + 1)'(llc_misses);
	assign instr_add = {1'b0, instr_q} + (SUM_WIDTH + 1)'(instructions);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q  <= '0;
			instr_q <= '0;
		end else if (ctrl.clr) begin
			miss_q  <= '0;
			instr_q <= '0;
		end else if (ctrl.add) begin
			// saturate at all ones
			miss_q  <= miss_add[SUM_WIDTH] ? '1 : miss_add[SUM_WIDTH-1:0];
			instr_q <= instr_add[SUM_WIDTH] ? '1 : instr_add[SUM_WIDTH-1:0];
		end
	end

	assign miss_sum  = miss_q;
	assign instr_sum = instr_q;

endmodule

FILE: src/mps_index_unit.sv
module mps_index_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mps_pkg::unit_req_t            req,
	input  logic [mps_pkg::SUM_WIDTH-1:0] miss_sum,
	input  logic [mps_pkg::SUM_WIDTH-1:0] instr_sum,
	output mps_pkg::unit_stat_t           stat
);
	import mps_pkg::*;

	typedef enum logic [1:0] {U_IDLE, U_MUL_L, U_MUL_P, U_CMP} ustate_t;

	ustate_t           state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CW-1:0]     mult_q;
	logic [MPKI_W-1:0] mx_q;
	logic [IDX_W-1:0]  n_q, idx_q;
	logic [PW-1:0]     acc_q, l_q, d_q;
	logic              done_q;

	logic          mul_mode, mul_bit, ge, more;
	logic [PW-1:0] operand, add_a, add_b, sum;

	always_comb begin
		mul_mode = (state_q == U_MUL_L) || (state_q == U_MUL_P);
		mul_bit  = (state_q == U_MUL_L) ? mult_q[cnt_q] : mx_q[cnt_q[MX_IDX_W-1:0]];
		operand  = (state_q == U_MUL_L) ? PW'(miss_sum) : PW'(instr_sum);
		// shared adder: shift-add multiply, then threshold stepping
		add_a    = mul_mode ? {acc_q[PW-2:0], 1'b0} : acc_q;
		add_b    = mul_mode ? (mul_bit ? operand : '0) : d_q;
		sum      = add_a + add_b;
		ge       = l_q >= acc_q;
		more     = idx_q < n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			mult_q  <= '0;
			mx_q    <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			acc_q   <= '0;
			l_q     <= '0;
			d_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						n_q    <= req.n;
						mx_q   <= req.mx;
						mult_q <= CW'(2 * SCALE) * CW'(req.n);
						acc_q  <= '0;
						idx_q  <= '0;
						cnt_q  <= CNT_W'(CW - 1);
						if (instr_sum == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= U_MUL_L;
						end
					end
				end
				U_MUL_L: begin
					if (cnt_q == '0) begin
						l_q     <= sum;
						acc_q   <= '0;
						cnt_q   <= CNT_W'(MPKI_W - 1);
						state_q <= U_MUL_P;
					end else begin
						acc_q <= sum;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_MUL_P: begin
					acc_q <= sum;
					if (cnt_q == '0) begin
						d_q     <= {sum[PW-2:0], 1'b0};
						state_q <= U_CMP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_CMP: begin
					if (ge && more) begin
						idx_q <= idx_q + 1'b1;
						acc_q <= sum;
					end else begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.idx  = idx_q;

endmodule

FILE: src/mpki_pstate_selector.sv
// MPKI-based P-state selector.
// item channel (item_valid/item_ready/item): action 0 adds the sample's miss
// and instruction counts into two saturating interval sums and gives no
// result. Action 1 ends the interval: it yields one result on the
// result channel (pstate_index, changed) and clears both sums.
// An end-of-interval request runs two shift-add multiplies on one shared
// adder, then one threshold step a cycle, before result_valid is raised.
// With no instructions counted the multiplies are skipped and the result
// is index 0.
// item_ready is low while a decision is in progress.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is max_mpki, index 1 is num_pstates; other indexes are ignored.
// Write it only when the block is idle.
// Reset clears the sums and held index and loads max_mpki 100, num_pstates 2.
// The result sits in an output register; if result_ready is low, samples are
// still taken, and a finished decision waits until the register is free.
module mpki_pstate_selector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  mps_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output mps_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mps_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_BUSY, T_LOAD} tstate_t;

	tstate_t           state_q;
	logic [MPKI_W-1:0] mpki_q;
	logic [NUM_W-1:0]  num_q;
	logic [PIDX_W-1:0] held_q;
	logic              result_valid_q;
	result_t           result_q;

	acc_ctrl_t            acc_ctrl;
	unit_req_t            ureq;
	unit_stat_t           ustat;
	logic [SUM_WIDTH-1:0] miss_sum, instr_sum;
	logic                 accept, load;
	logic [IDX_W-1:0]     n_eff;
	logic [31:0]          idx_ext;
	logic [PIDX_W-1:0]    new_idx;

	assign item_ready = (state_q == T_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && item_ready;
	assign load       = (state_q == T_LOAD) && (!result_valid_q || result_ready);

	always_comb begin
		if (num_q < NUM_W'(2)) begin
			n_eff = IDX_W'(1);
		end else if ({1'b0, num_q} > (NUM_W + 1)'(MAX_PSTATES)) begin
			n_eff = IDX_W'(MAX_PSTATES - 1);
		end else begin
			n_eff = IDX_W'(num_q - 1'b1);
		end
		ureq.start   = accept && item.action;
		ureq.n       = n_eff;
		ureq.mx      = (mpki_q == '0) ? MPKI_W'(1) : mpki_q;
		acc_ctrl.add = accept && !item.action;
		acc_ctrl.clr = load;
		idx_ext      = 32'(ustat.idx);
		new_idx      = idx_ext[PIDX_W-1:0];
	end

	mps_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (acc_ctrl),
		.llc_misses   (item.llc_misses),
		.instructions (item.instructions),
		.miss_sum     (miss_sum),
		.instr_sum    (instr_sum)
	);

	mps_index_unit u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ureq),
		.miss_sum  (miss_sum),
		.instr_sum (instr_sum),
		.stat      (ustat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpki_q <= MAX_MPKI_RST;
			num_q  <= NUM_PSTATES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_MPKI:    mpki_q <= cfg_data[MPKI_W-1:0];
				REG_NUM_PSTATES: num_q  <= cfg_data[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_IDLE;
			held_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && !load) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept && item.action) begin
						state_q <= T_BUSY;
					end
				end
				T_BUSY: begin
					if (ustat.done) begin
						state_q <= T_LOAD;
					end
				end
				T_LOAD: begin
					if (load) begin
						result_q.pstate_index <= new_idx;
						result_q.changed      <= (new_idx != held_q);
						held_q                <= new_idx;
						result_valid_q        <= 1'b1;
						state_q               <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: src/mps_checker.sv
module mps_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input mps_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input mps_pkg::result_t result,
	input logic             cfg_valid,
	input logic             cfg_ready
);
	import mps_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.action |=> !item_ready)
		else $error("ready during interval decision");

	a_sample_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !item.action |=> item_ready)
		else $error("sample request stalled the block");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result appeared without a decision in progress");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind mpki_pstate_selector mps_checker u_mps_checker (.*);
